// ===== src/gdh_pkg.sv =====
package gdh_pkg;

   // default widths
   localparam int COORD_BITS_DEF = 10;
   localparam int COST_BITS_DEF  = 8;
   localparam int OUT_BITS       = 19;
   localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

   // configuration register indexes
   localparam int CSR_IDX_BITS = 1;
   localparam logic [CSR_IDX_BITS-1:0] REG_STRAIGHT = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_DIAGONAL = 1'b1;

   // configuration reset values
   localparam int STRAIGHT_RESET = 10;
   localparam int DIAGONAL_RESET = 14;

   // distance modes
   localparam logic [1:0] CMD_MANHATTAN = 2'd0;
   localparam logic [1:0] CMD_EUCLIDEAN = 2'd1;
   localparam logic [1:0] CMD_OCTILE    = 2'd2;
   localparam logic [1:0] CMD_CHEBYSHEV = 2'd3;

endpackage

// ===== src/gdh_front.sv =====
module gdh_front import gdh_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COST_BITS  = COST_BITS_DEF,
   parameter int PW = COST_BITS + COORD_BITS + 1,
   parameter int NW = 2 * (COST_BITS + COORD_BITS + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_stall,
   input  logic [1:0]            in_cmd,
   input  logic [COORD_BITS-1:0] in_from_x,
   input  logic [COORD_BITS-1:0] in_from_y,
   input  logic [COORD_BITS-1:0] in_to_x,
   input  logic [COORD_BITS-1:0] in_to_y,
   input  logic [COST_BITS-1:0]  straight,
   input  logic [COST_BITS-1:0]  diagonal,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [1:0]            out_cmd,
   output logic [PW-1:0]         out_alt,
   output logic [NW-1:0]         out_n
);

   localparam int MW = COST_BITS + COORD_BITS;
   localparam int SW = 2 * MW;

   // stage 1: distances along each axis
   logic                  v1_ff;
   logic [1:0]            cmd1_ff;
   logic [COORD_BITS-1:0] dx1_ff, dy1_ff, mn1_ff, mx1_ff;
   logic [COORD_BITS-1:0] dx_in, dy_in;
   logic                  stall1;

   // stage 2: step-cost products
   logic            v2_ff;
   logic [1:0]      cmd2_ff;
   logic [MW-1:0]   sdx2_ff, sdy2_ff, pmn2_ff, pdiff2_ff, pmx2_ff;
   logic            stall2;

   // stage 3: squares and non-euclidean cost
   logic            v3_ff;
   logic [1:0]      cmd3_ff;
   logic [SW-1:0]   sqx3_ff, sqy3_ff;
   logic [PW-1:0]   alt3_ff, alt_in;
   logic            stall3;

   // stage 4: radicand
   logic            v4_ff;
   logic [1:0]      cmd4_ff;
   logic [PW-1:0]   alt4_ff;
   logic [NW-1:0]   n4_ff;
   logic            stall4;

   assign stall4   = v4_ff && out_stall;
   assign stall3   = v3_ff && stall4;
   assign stall2   = v2_ff && stall3;
   assign stall1   = v1_ff && stall2;
   assign in_stall = stall1;

   assign dx_in = (in_from_x > in_to_x) ? in_from_x - in_to_x : in_to_x - in_from_x;
   assign dy_in = (in_from_y > in_to_y) ? in_from_y - in_to_y : in_to_y - in_from_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (!stall1) begin
         v1_ff <= in_valid;
      end
      if (!stall1) begin
         cmd1_ff <= in_cmd;
         dx1_ff  <= dx_in;
         dy1_ff  <= dy_in;
         mn1_ff  <= (dx_in < dy_in) ? dx_in : dy_in;
         mx1_ff  <= (dx_in < dy_in) ? dy_in : dx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (!stall2) begin
         v2_ff <= v1_ff;
      end
      if (!stall2) begin
         cmd2_ff   <= cmd1_ff;
         sdx2_ff   <= MW'(straight) * MW'(dx1_ff);
         sdy2_ff   <= MW'(straight) * MW'(dy1_ff);
         pmn2_ff   <= MW'(diagonal) * MW'(mn1_ff);
         pdiff2_ff <= MW'(straight) * MW'(mx1_ff - mn1_ff);
         pmx2_ff   <= MW'(straight) * MW'(mx1_ff);
      end
   end

   // cost for the modes that need no square root
   always_comb begin
      unique case (cmd2_ff)
         CMD_MANHATTAN: alt_in = PW'(sdx2_ff) + PW'(sdy2_ff);
         CMD_EUCLIDEAN: alt_in = '0;
         CMD_OCTILE:    alt_in = PW'(pmn2_ff) + PW'(pdiff2_ff);
         CMD_CHEBYSHEV: alt_in = PW'(pmx2_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (!stall3) begin
         v3_ff <= v2_ff;
      end
      if (!stall3) begin
         cmd3_ff <= cmd2_ff;
         alt3_ff <= alt_in;
         sqx3_ff <= SW'(sdx2_ff) * SW'(sdx2_ff);
         sqy3_ff <= SW'(sdy2_ff) * SW'(sdy2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (!stall4) begin
         v4_ff <= v3_ff;
      end
      if (!stall4) begin
         cmd4_ff <= cmd3_ff;
         alt4_ff <= alt3_ff;
         n4_ff   <= NW'(sqx3_ff) + NW'(sqy3_ff);
      end
   end

   assign out_valid = v4_ff;
   assign out_cmd   = cmd4_ff;
   assign out_alt   = alt4_ff;
   assign out_n     = n4_ff;

endmodule

// ===== src/gdh_root_cell.sv =====
module gdh_root_cell import gdh_pkg::*; #(
   parameter int RW     = COST_BITS_DEF + COORD_BITS_DEF + 1,
   parameter int SIDE_W = 2 + RW
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_stall,
   input  logic [2*RW-1:0]   in_n,
   input  logic [RW+1:0]     in_rem,
   input  logic [RW-1:0]     in_root,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   input  logic              out_stall,
   output logic [2*RW-1:0]   out_n,
   output logic [RW+1:0]     out_rem,
   output logic [RW-1:0]     out_root,
   output logic [SIDE_W-1:0] out_side
);

   localparam int NW = 2 * RW;

   logic              valid_ff;
   logic [NW-1:0]     n_ff;
   logic [RW+1:0]     rem_ff;
   logic [RW-1:0]     root_ff;
   logic [SIDE_W-1:0] side_ff;

   logic [RW+1:0]     rem_sh, trial, rem_in;
   logic [RW-1:0]     root_in;
   logic              take;

   assign in_stall = valid_ff && out_stall;

   // one root bit: bring down two radicand bits and try root*4+1
   assign rem_sh  = {in_rem[RW-1:0], in_n[NW-1 -: 2]};
   assign trial   = {in_root, 2'b01};
   assign take    = rem_sh >= trial;
   assign rem_in  = take ? rem_sh - trial : rem_sh;
   assign root_in = {in_root[RW-2:0], take};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
      if (!in_stall) begin
         n_ff    <= {in_n[NW-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_n     = n_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_side  = side_ff;

`ifndef SYNTH
   // partial remainder never exceeds twice the partial root
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> rem_ff <= {1'b0, root_ff, 1'b0})
      else $error("root cell remainder out of range");

   // a held transaction keeps its root and remainder
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_stall) |=> (valid_ff && $stable(root_ff) && $stable(rem_ff)))
      else $error("root cell lost a stalled transaction");

   // an empty cell never pushes back
   a_no_stall_empty: assert property (@(posedge clock) disable iff (reset)
      !valid_ff |-> !in_stall)
      else $error("root cell stalls while empty");
`endif

endmodule

// ===== src/grid_distance_heuristic.sv =====
// grid distance heuristic cost unit
// path: a request passes four front stages, one root cell per root bit and
//   one output register on its way to the response
// throughput: one transaction per cycle while rsp_stall is low, set by the one-bit-per-cell square root chain
// reset: synchronous active-high reset empties the pipeline and loads step costs 10 and 14
module grid_distance_heuristic import gdh_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COST_BITS  = COST_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COST_BITS-1:0]    csr_wr_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_cmd,
   input  logic [COORD_BITS-1:0]   req_from_x,
   input  logic [COORD_BITS-1:0]   req_from_y,
   input  logic [COORD_BITS-1:0]   req_to_x,
   input  logic [COORD_BITS-1:0]   req_to_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [OUT_BITS-1:0]     rsp_cost
);

   localparam int RW     = COST_BITS + COORD_BITS + 1;
   localparam int PW     = RW;
   localparam int NW     = 2 * RW;
   localparam int SIDE_W = 2 + PW;
   localparam int VW     = RW + 1;
   localparam int WW     = (VW > OUT_BITS) ? VW : OUT_BITS;

   // configuration registers
   logic [COST_BITS-1:0] straight_ff, diagonal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         straight_ff <= COST_BITS'(STRAIGHT_RESET);
         diagonal_ff <= COST_BITS'(DIAGONAL_RESET);
      end else if (csr_wr_en) begin
         if (csr_index == REG_STRAIGHT) begin
            straight_ff <= csr_wr_data;
         end
         if (csr_index == REG_DIAGONAL) begin
            diagonal_ff <= csr_wr_data;
         end
      end
   end

   // front stages
   logic            f_valid, f_stall;
   logic [1:0]      f_cmd;
   logic [PW-1:0]   f_alt;
   logic [NW-1:0]   f_n;

   gdh_front #(
      .COORD_BITS (COORD_BITS),
      .COST_BITS  (COST_BITS),
      .PW         (PW),
      .NW         (NW)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_cmd    (req_cmd),
      .in_from_x (req_from_x),
      .in_from_y (req_from_y),
      .in_to_x   (req_to_x),
      .in_to_y   (req_to_y),
      .straight  (straight_ff),
      .diagonal  (diagonal_ff),
      .out_valid (f_valid),
      .out_stall (f_stall),
      .out_cmd   (f_cmd),
      .out_alt   (f_alt),
      .out_n     (f_n)
   );

   // square root chain, one cell per root bit
   logic              c_valid [RW+1];
   logic              c_stall [RW+1];
   logic [NW-1:0]     c_n     [RW+1];
   logic [RW+1:0]     c_rem   [RW+1];
   logic [RW-1:0]     c_root  [RW+1];
   logic [SIDE_W-1:0] c_side  [RW+1];

   assign c_valid[0] = f_valid;
   assign f_stall    = c_stall[0];
   assign c_n[0]     = f_n;
   assign c_rem[0]   = '0;
   assign c_root[0]  = '0;
   assign c_side[0]  = {f_cmd, f_alt};

   for (genvar i = 0; i < RW; i++) begin : g_cell
      gdh_root_cell #(
         .RW     (RW),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[i]),
         .in_stall  (c_stall[i]),
         .in_n      (c_n[i]),
         .in_rem    (c_rem[i]),
         .in_root   (c_root[i]),
         .in_side   (c_side[i]),
         .out_valid (c_valid[i+1]),
         .out_stall (c_stall[i+1]),
         .out_n     (c_n[i+1]),
         .out_rem   (c_rem[i+1]),
         .out_root  (c_root[i+1]),
         .out_side  (c_side[i+1])
      );
   end

   // rounding, mode select and saturation
   logic                rsp_valid_ff;
   logic [OUT_BITS-1:0] rsp_cost_ff;
   logic                o_stall;
   logic [1:0]          l_cmd;
   logic [PW-1:0]       l_alt;
   logic [VW-1:0]       euclid, value;
   logic [WW-1:0]       value_wide;
   logic [OUT_BITS-1:0] cost_in;

   assign l_cmd = c_side[RW][SIDE_W-1 -: 2];
   assign l_alt = c_side[RW][PW-1:0];

   assign euclid = (c_rem[RW] > {2'b00, c_root[RW]}) ? VW'(c_root[RW]) + VW'(1)
                                                      : VW'(c_root[RW]);
   assign value      = (l_cmd == CMD_EUCLIDEAN) ? euclid : VW'(l_alt);
   assign value_wide = WW'(value);
   assign cost_in    = (value_wide > WW'(OUT_MAX)) ? OUT_MAX : value_wide[OUT_BITS-1:0];

   assign o_stall     = rsp_valid_ff && rsp_stall;
   assign c_stall[RW] = o_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!o_stall) begin
         rsp_valid_ff <= c_valid[RW];
      end
      if (!o_stall) begin
         rsp_cost_ff <= cost_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cost  = rsp_cost_ff;

endmodule

// ===== sim/gdh_cost_checker.sv =====
module gdh_cost_checker import gdh_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COST_BITS  = COST_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [COST_BITS-1:0]    csr_wr_data,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [1:0]              req_cmd,
   input  logic [COORD_BITS-1:0]   req_from_x,
   input  logic [COORD_BITS-1:0]   req_from_y,
   input  logic [COORD_BITS-1:0]   req_to_x,
   input  logic [COORD_BITS-1:0]   req_to_y,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [OUT_BITS-1:0]     rsp_cost,
   output int                      fail_count,
   output int                      pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [COST_BITS-1:0] straight_step;
   logic [COST_BITS-1:0] diagonal_step;
   logic [OUT_BITS-1:0]  expected_costs [$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // floor of the square root, one bit at a time
   function automatic longint unsigned root_floor(longint unsigned n);
      longint unsigned r;
      longint unsigned cand;
      r = 0;
      for (int b = 31; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         if (cand * cand <= n) r = cand;
      end
      return r;
   endfunction

   // weighted distance for one query, saturated to the result width
   function automatic logic [OUT_BITS-1:0] weighted_cost(
      logic [1:0]            mode,
      logic [COORD_BITS-1:0] fx,
      logic [COORD_BITS-1:0] fy,
      logic [COORD_BITS-1:0] tx,
      logic [COORD_BITS-1:0] ty,
      logic [COST_BITS-1:0]  s,
      logic [COST_BITS-1:0]  d
   );
      longint unsigned dx, dy, mn, mx, n, r, total;
      dx = (fx > tx) ? fx - tx : tx - fx;
      dy = (fy > ty) ? fy - ty : ty - fy;
      mn = (dx < dy) ? dx : dy;
      mx = (dx < dy) ? dy : dx;
      case (mode)
         CMD_MANHATTAN: total = s * (dx + dy);
         CMD_EUCLIDEAN: begin
            // round half up of s*sqrt(dx^2+dy^2), exact in integers
            n = s * s * (dx * dx + dy * dy);
            r = root_floor(n);
            total = (n - r * r > r) ? r + 1 : r;
         end
         CMD_OCTILE:    total = d * mn + s * (mx - mn);
         default:       total = s * mx;
      endcase
      if (total > OUT_MAX) return OUT_MAX;
      return total[OUT_BITS-1:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         straight_step = COST_BITS'(STRAIGHT_RESET);
         diagonal_step = COST_BITS'(DIAGONAL_RESET);
         expected_costs.delete();
      end else begin
         // step cost register writes
         if (csr_wr_en) begin
            if (csr_index == REG_STRAIGHT) straight_step = csr_wr_data;
            else if (csr_index == REG_DIAGONAL) diagonal_step = csr_wr_data;
         end
         // accepted request transaction
         if (req_valid && !req_stall)
            expected_costs.push_back(weighted_cost(req_cmd, req_from_x, req_from_y,
                                                   req_to_x, req_to_y,
                                                   straight_step, diagonal_step));
         // accepted response transaction
         if (rsp_valid && !rsp_stall) begin
            if (expected_costs.size() == 0) begin
               $display("%0t: unexpected response, expected none, got cost %0d",
                        $time, rsp_cost);
               fail_count++;
            end else begin
               logic [OUT_BITS-1:0] want;
               want = expected_costs.pop_front();
               if (rsp_cost !== want) begin
                  $display("%0t: cost mismatch, expected %0d, got %0d",
                           $time, want, rsp_cost);
                  fail_count++;
               end
            end
         end
      end
      pending = expected_costs.size();
   end

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
   import gdh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS   = COORD_BITS_DEF;
   localparam int COST_BITS    = COST_BITS_DEF;
   localparam int LATENCY      = COST_BITS + COORD_BITS + 6;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 200;
   localparam int RAND_PHASES  = 7;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [COORD_BITS-1:0] CMAX = '1;
   localparam logic [COST_BITS-1:0]  SMAX = '1;

   logic                    clock       = 1'b0;
   logic                    reset       = 1'b1;
   logic                    csr_wr_en   = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index   = REG_STRAIGHT;
   logic [COST_BITS-1:0]    csr_wr_data = '0;
   logic                    req_valid   = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_cmd     = CMD_MANHATTAN;
   logic [COORD_BITS-1:0]   req_from_x  = '0;
   logic [COORD_BITS-1:0]   req_from_y  = '0;
   logic [COORD_BITS-1:0]   req_to_x    = '0;
   logic [COORD_BITS-1:0]   req_to_y    = '0;
   logic                    rsp_valid;
   logic                    rsp_stall   = 1'b0;
   logic [OUT_BITS-1:0]     rsp_cost;

   int fail_count;
   int pending;
   int cycle_count = 0;
   bit no_idle     = 1'b0;

   always #5 clock = ~clock;

   grid_distance_heuristic #(
      .COORD_BITS(COORD_BITS),
      .COST_BITS (COST_BITS)
   ) dut (.*);

   gdh_cost_checker #(
      .COORD_BITS(COORD_BITS),
      .COST_BITS (COST_BITS)
   ) checker_i (.*);

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // response side: random stalls, burst stretches and two long hold-offs
   initial begin
      int taken;
      int gap;
      taken = 0;
      forever begin
         if (taken == 300 || taken == 1100) gap = HOLD_CYCLES;
         else gap = no_idle ? 0 : $urandom_range(0, 17);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!(rsp_valid && !rsp_stall)) @(posedge clock);
         taken++;
         @(negedge clock);
      end
   end

   // one request transaction, with a random gap ahead of it
   task automatic send_query(logic [1:0] mode, logic [COORD_BITS-1:0] fx,
                             logic [COORD_BITS-1:0] fy, logic [COORD_BITS-1:0] tx,
                             logic [COORD_BITS-1:0] ty);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_cmd    <= mode;
      req_from_x <= fx;
      req_from_y <= fy;
      req_to_x   <= tx;
      req_to_y   <= ty;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // drop valid and let every outstanding cost come back
   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // both step costs, written only while the pipeline is empty
   task automatic set_costs(logic [COST_BITS-1:0] s, logic [COST_BITS-1:0] d);
      drain();
      csr_wr_en   <= 1'b1;
      csr_index   <= REG_STRAIGHT;
      csr_wr_data <= s;
      @(negedge clock);
      csr_index   <= REG_DIAGONAL;
      csr_wr_data <= d;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return CMAX;
         default: return COORD_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [COST_BITS-1:0] pick_cost();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return SMAX;
         default: return COST_BITS'($urandom);
      endcase
   endfunction

   // random query: far points, coincident points or close neighbors
   task automatic send_random();
      logic [COORD_BITS-1:0] fx, fy, tx, ty;
      int sel;
      fx  = pick_coord();
      fy  = pick_coord();
      sel = $urandom_range(0, 7);
      if (sel == 0) begin
         tx = fx;
         ty = fy;
      end else if (sel <= 3) begin
         tx = fx + COORD_BITS'($urandom_range(0, 16)) - COORD_BITS'(8);
         ty = fy + COORD_BITS'($urandom_range(0, 16)) - COORD_BITS'(8);
      end else begin
         tx = pick_coord();
         ty = pick_coord();
      end
      send_query(2'($urandom_range(0, 3)), fx, fy, tx, ty);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset step costs: zero distance, full diagonal, textbook points
      send_query(CMD_MANHATTAN, 0, 0, 0, 0);
      send_query(CMD_EUCLIDEAN, 0, 0, 0, 0);
      send_query(CMD_OCTILE,    0, 0, 0, 0);
      send_query(CMD_CHEBYSHEV, 0, 0, 0, 0);
      send_query(CMD_MANHATTAN, 0, 0, CMAX, CMAX);
      send_query(CMD_EUCLIDEAN, 0, 0, CMAX, CMAX);
      send_query(CMD_OCTILE,    0, 0, CMAX, CMAX);
      send_query(CMD_CHEBYSHEV, 0, 0, CMAX, CMAX);
      send_query(CMD_MANHATTAN, CMAX, 0, 0, CMAX);
      send_query(CMD_EUCLIDEAN, 0, 0, 3, 4);
      send_query(CMD_EUCLIDEAN, 5, 5, 6, 6);
      send_query(CMD_OCTILE,    100, 200, 103, 210);
      send_query(CMD_CHEBYSHEV, CMAX, CMAX, 0, 5);

      // largest step costs give the largest results
      set_costs(SMAX, SMAX);
      send_query(CMD_MANHATTAN, 0, 0, CMAX, CMAX);
      send_query(CMD_EUCLIDEAN, CMAX, CMAX, 0, 0);
      send_query(CMD_OCTILE,    0, CMAX, CMAX, 0);
      send_query(CMD_CHEBYSHEV, 0, 0, CMAX, CMAX);
      send_query(CMD_EUCLIDEAN, CMAX, 0, 0, CMAX - 1);

      // zero step costs
      set_costs(0, 0);
      send_query(CMD_MANHATTAN, 0, 0, CMAX, CMAX);
      send_query(CMD_OCTILE,    CMAX, 0, 0, CMAX);

      // free straight steps, expensive diagonals
      set_costs(0, SMAX);
      send_query(CMD_OCTILE,    0, 0, CMAX, 512);
      send_query(CMD_EUCLIDEAN, 0, 0, CMAX, 512);
      send_query(CMD_CHEBYSHEV, 0, 0, CMAX, 512);

      // random phases, each with its own step costs and pacing
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         if (ph == 0) set_costs(COST_BITS'(STRAIGHT_RESET), COST_BITS'(DIAGONAL_RESET));
         else set_costs(pick_cost(), pick_cost());
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
            send_random();
         end
      end
      no_idle = 1'b0;

      // wait for the last costs, then the pipeline depth once more
      drain();
      repeat (LATENCY + 4) @(negedge clock);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
